>>> rtl/core/etfp_pkg.sv
// Shared types, widths and register codes for the escape-time fractal pixel block.
package etfp_pkg;

  localparam int PT_W      = 30;
  localparam int Z_W       = 32;
  localparam int PROD_W    = 2 * Z_W;
  localparam int FRAC_BITS = 26;
  localparam int SUM_W     = 40;
  localparam int RAD_W     = 29;
  localparam int LIM_W     = 2 * RAD_W;
  localparam int MAX_W     = 16;
  localparam int CNT_W     = MAX_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 30;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(134217728);
  localparam logic [MAX_W-1:0] MAX_ITER_RESET = MAX_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_FIXED_RE = 3'd1,
    REG_FIXED_IM = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_idx_t;

  typedef enum logic {
    MODE_MANDELBROT = 1'b0,
    MODE_JULIA      = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [PT_W-1:0]   fixed_re;
    logic [PT_W-1:0]   fixed_im;
    logic [RAD_W-1:0]  escape_radius;
    logic [MAX_W-1:0]  max_iterations;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
  } dp_sts_t;

  function automatic logic signed [Z_W-1:0] clamp_z(input logic signed [SUM_W-1:0] v);
    logic signed [Z_W-1:0] r;
    if (v[SUM_W-1:Z_W-1] == {(SUM_W-Z_W+1){1'b0}} ||
        v[SUM_W-1:Z_W-1] == {(SUM_W-Z_W+1){1'b1}}) begin
      r = v[Z_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Z_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/etfp_cfg.sv
// Configuration register file with write channel decode.
module etfp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [etfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etfp_pkg::CFG_DATA_W-1:0] cfg_data,
  output etfp_pkg::cfg_t                  cfg
);
  import etfp_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_MANDELBROT;
      cfg.fixed_re       <= '0;
      cfg.fixed_im       <= '0;
      cfg.escape_radius  <= RADIUS_RESET;
      cfg.max_iterations <= MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:     cfg.mode           <= mode_t'(cfg_data[0]);
        REG_FIXED_RE: cfg.fixed_re       <= cfg_data[PT_W-1:0];
        REG_FIXED_IM: cfg.fixed_im       <= cfg_data[PT_W-1:0];
        REG_RADIUS:   cfg.escape_radius  <= cfg_data[RAD_W-1:0];
        REG_MAX_ITER: cfg.max_iterations <= cfg_data[MAX_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/etfp_dp.sv
// Datapath: z and c registers, squaring products, escape test and result word.
module etfp_dp #(
  parameter int COLOR_COUNT = 32,
  parameter int COLOR_W     = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  etfp_pkg::cfg_t                     cfg,
  input  logic signed [etfp_pkg::PT_W-1:0]   point_re,
  input  logic signed [etfp_pkg::PT_W-1:0]   point_im,
  input  etfp_pkg::dp_cmd_t                  cmd,
  output etfp_pkg::dp_sts_t                  sts,
  output logic [etfp_pkg::CNT_W-1:0]         iteration_count,
  output logic                               inside_res,
  output logic [COLOR_W-1:0]                 color_index
);
  import etfp_pkg::*;

  logic signed [Z_W-1:0]    zr, zi;
  logic signed [PT_W-1:0]   cr, ci;
  logic [LIM_W-1:0]         limit;
  logic signed [PROD_W-1:0] rr, ii, ri;
  logic [CNT_W-1:0]         count;
  logic [COLOR_W-1:0]       color_cnt;

  logic [PROD_W-1:0]        mag;
  logic signed [PROD_W-1:0] diff;
  logic signed [SUM_W-1:0]  re_sum, im_sum;
  logic                     over;

  assign mag    = rr + ii;
  assign diff   = rr - ii;
  assign re_sum = {{(SUM_W-PROD_W+FRAC_BITS){diff[PROD_W-1]}}, diff[PROD_W-1:FRAC_BITS]}
                + {{(SUM_W-PT_W){cr[PT_W-1]}}, cr};
  assign im_sum = {{(SUM_W-PROD_W+FRAC_BITS-1){ri[PROD_W-1]}}, ri[PROD_W-1:FRAC_BITS-1]}
                + {{(SUM_W-PT_W){ci[PT_W-1]}}, ci};
  assign over     = count > {1'b0, cfg.max_iterations};
  assign sts.stop = !(mag < {{(PROD_W-LIM_W){1'b0}}, limit}) || over;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cfg.mode == MODE_MANDELBROT) begin
        cr <= point_re;
        ci <= point_im;
        zr <= {{(Z_W-PT_W){cfg.fixed_re[PT_W-1]}}, cfg.fixed_re};
        zi <= {{(Z_W-PT_W){cfg.fixed_im[PT_W-1]}}, cfg.fixed_im};
      end else begin
        cr <= cfg.fixed_re;
        ci <= cfg.fixed_im;
        zr <= {{(Z_W-PT_W){point_re[PT_W-1]}}, point_re};
        zi <= {{(Z_W-PT_W){point_im[PT_W-1]}}, point_im};
      end
      limit     <= cfg.escape_radius * cfg.escape_radius;
      count     <= '0;
      color_cnt <= '0;
    end else if (cmd.step) begin
      zr    <= clamp_z(re_sum);
      zi    <= clamp_z(im_sum);
      count <= count + CNT_W'(1);
      if (color_cnt == COLOR_W'(COLOR_COUNT - 1)) begin
        color_cnt <= '0;
      end else begin
        color_cnt <= color_cnt + COLOR_W'(1);
      end
    end
    if (cmd.mul) begin
      rr <= zr * zr;
      ii <= zi * zi;
      ri <= zr * zi;
    end
    if (cmd.finish) begin
      iteration_count <= count;
      inside_res      <= over;
      color_index     <= over ? '0 : color_cnt;
    end
  end

`ifndef SYNTH
  a_step_count: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> count == $past(count) + CNT_W'(1))
    else $error("count did not advance on step");
  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (!inside_res || color_index == '0))
    else $error("inside point with nonzero color");
  a_color_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> color_cnt <= COLOR_W'(COLOR_COUNT - 1))
    else $error("color counter out of range");
`endif

endmodule

>>> rtl/core/etfp_ctrl.sv
// Controller: sequences load, multiply and update cycles and raises the result strobe.
module etfp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output etfp_pkg::dp_cmd_t   cmd,
  input  etfp_pkg::dp_sts_t   sts
);
  import etfp_pkg::*;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (sts.stop) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

`ifndef SYNTH
  a_done_after_upd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPD))
    else $error("result strobe without update cycle");
  a_start_to_mul: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == S_MUL)
    else $error("accepted word did not enter multiply");
  a_mul_to_upd: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> state == S_UPD)
    else $error("multiply not followed by update");
`endif

endmodule

>>> rtl/core/escape_time_fractal_pixel.sv
// Escape-time fractal pixel evaluator (Mandelbrot / Julia), Q4.26 coordinates, Q6.26 z registers.
// Each accepted point is loaded, then each test of z runs an S_MUL state and an S_UPD state;
// iteration_count gives the iterations run (0 to max+1).
// Throughput: one word at a time; start is taken again in the cycle done is high.
// Reset (rst, synchronous): controller idles, config registers return to defaults.
// The result strobe done lasts one cycle and the receiver cannot stall it.
module escape_time_fractal_pixel #(
  parameter int COLOR_COUNT = 32,
  localparam int COLOR_W    = $clog2(COLOR_COUNT)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [etfp_pkg::PT_W-1:0]   point_re,
  input  logic signed [etfp_pkg::PT_W-1:0]   point_im,
  output logic                               done,
  output logic [etfp_pkg::CNT_W-1:0]         iteration_count,
  output logic                               inside_res,
  output logic [COLOR_W-1:0]                 color_index,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [etfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [etfp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import etfp_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  etfp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  etfp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  etfp_dp #(
    .COLOR_COUNT (COLOR_COUNT),
    .COLOR_W     (COLOR_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .point_re        (point_re),
    .point_im        (point_im),
    .cmd             (cmd),
    .sts             (sts),
    .iteration_count (iteration_count),
    .inside_res      (inside_res),
    .color_index     (color_index)
  );

endmodule

>>> test/escape_time_fractal_pixel_tb.sv
// Self-checking testbench: escape-time fractal pixel evaluator against a fixed-point predictor.
`timescale 1ns / 1ps

module escape_time_fractal_pixel_tb;
  import etfp_pkg::*;

  localparam int COLOR_COUNT   = 32;
  localparam int COLOR_W       = $clog2(COLOR_COUNT);
  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int STALL_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 600;
  localparam int RANDOM_PHASES = 22;
  localparam int PHASE_ITEMS   = 61;
  localparam int PRINT_LIMIT   = 100;
  localparam int SPARE_FIRST   = REG_MAX_ITER + 1;

  localparam longint ONE  = longint'(1) << FRAC_BITS;
  localparam longint Z_HI = 64'sd2147483647;
  localparam longint Z_LO = -64'sd2147483648;

  typedef logic signed [PT_W-1:0] pt_t;

  localparam pt_t PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
  localparam pt_t PT_MIN = {1'b1, {(PT_W-1){1'b0}}};
  localparam logic [RAD_W-1:0] RAD_TOP  = {RAD_W{1'b1}};
  localparam logic [RAD_W-1:0] RAD_FOUR = RAD_W'(4 * ONE);

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic               inside_flag;
    logic [COLOR_W-1:0] color;
  } escape_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pt_t point_re = '0;
  pt_t point_im = '0;
  logic done;
  logic [CNT_W-1:0] iteration_count;
  logic inside_res;
  logic [COLOR_W-1:0] color_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mode_t mode_q = MODE_MANDELBROT;
  pt_t fixed_re_q = '0;
  pt_t fixed_im_q = '0;
  logic [RAD_W-1:0] radius_q = RADIUS_RESET;
  logic [MAX_W-1:0] max_iter_q = MAX_ITER_RESET;

  escape_result_t pending_results[$];
  escape_result_t want_result;
  int mismatch_count = 0;
  int stall_cycles = 0;

  escape_time_fractal_pixel #(
    .COLOR_COUNT(COLOR_COUNT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .point_re(point_re),
    .point_im(point_im),
    .done(done),
    .iteration_count(iteration_count),
    .inside_res(inside_res),
    .color_index(color_index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic longint saturate_z(input longint v);
    if (v > Z_HI) return Z_HI;
    if (v < Z_LO) return Z_LO;
    return v;
  endfunction

  function automatic escape_result_t predict_escape(input pt_t pr, input pt_t pi);
    longint cr, ci, zr, zi, rr, ii, ri;
    longint unsigned mag, lim, count;
    escape_result_t res;
    lim = radius_q;
    lim = lim * lim;
    if (mode_q == MODE_MANDELBROT) begin
      cr = pr;
      ci = pi;
      zr = fixed_re_q;
      zi = fixed_im_q;
    end else begin
      cr = fixed_re_q;
      ci = fixed_im_q;
      zr = pr;
      zi = pi;
    end
    count = 0;
    rr = zr * zr;
    ii = zi * zi;
    mag = $unsigned(rr) + $unsigned(ii);
    while (mag < lim && count <= max_iter_q) begin
      count++;
      ri = zr * zi;
      zr = saturate_z(((rr - ii) >>> FRAC_BITS) + cr);
      zi = saturate_z((ri >>> (FRAC_BITS - 1)) + ci);
      rr = zr * zr;
      ii = zi * zi;
      mag = $unsigned(rr) + $unsigned(ii);
    end
    res.count = count[CNT_W-1:0];
    res.inside_flag = (count > max_iter_q);
    res.color = res.inside_flag ? '0 : COLOR_W'(count % COLOR_COUNT);
    return res;
  endfunction

  function automatic int idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic pt_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return pt_t'($urandom);
    if (pick < 8) return pt_t'(longint'($urandom_range(0, 4 * ONE)) - 2 * ONE);
    return pt_t'(longint'($urandom_range(0, 2047)) - 1024);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic issue_point(input pt_t re, input pt_t im, input int idle);
    if (idle > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    point_re = re;
    point_im = im;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_escape(re, im));
  endtask

  task automatic settle_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:     mode_q = mode_t'(data[0]);
      REG_FIXED_RE: fixed_re_q = data;
      REG_FIXED_IM: fixed_im_q = data;
      REG_RADIUS:   radius_q = data[RAD_W-1:0];
      REG_MAX_ITER: max_iter_q = data[MAX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_config(input mode_t m, input pt_t fre, input pt_t fim,
                             input logic [RAD_W-1:0] r, input logic [MAX_W-1:0] n);
    logic [CFG_DATA_W-1:0] word;
    settle_results();
    word = $urandom;
    word[0] = m;
    write_reg(REG_MODE, word);
    write_reg(REG_FIXED_RE, fre);
    write_reg(REG_FIXED_IM, fim);
    word = $urandom;
    word[RAD_W-1:0] = r;
    write_reg(REG_RADIUS, word);
    word = $urandom;
    word[MAX_W-1:0] = n;
    write_reg(REG_MAX_ITER, word);
  endtask

  task automatic test_default_config();
    issue_point('0, '0, 0);
    issue_point(PT_MAX, PT_MAX, 0);
    issue_point(PT_MIN, PT_MIN, 1);
    issue_point(PT_MAX, PT_MIN, 0);
    issue_point(PT_MIN, PT_MAX, 2);
    issue_point(pt_t'(-ONE), '0, 0);
    issue_point(pt_t'(ONE / 4), '0, idle_len());
    issue_point(pt_t'(1), pt_t'(-1), 0);
  endtask

  task automatic test_iteration_limits();
    load_config(MODE_MANDELBROT, '0, '0, RADIUS_RESET, '0);
    issue_point('0, '0, 0);
    issue_point(pt_t'(3 * ONE), '0, 0);
    load_config(MODE_MANDELBROT, '0, '0, RADIUS_RESET, '1);
    issue_point('0, '0, 0);
  endtask

  task automatic test_radius_extremes();
    load_config(MODE_MANDELBROT, '0, '0, '0, MAX_ITER_RESET);
    issue_point('0, '0, 0);
    load_config(MODE_MANDELBROT, '0, '0, RAD_FOUR, MAX_ITER_RESET);
    issue_point(pt_t'(3 * ONE), '0, 0);
    issue_point(pt_t'(-2 * ONE), '0, 1);
    issue_point(PT_MIN, '0, 0);
  endtask

  task automatic test_julia();
    load_config(MODE_JULIA, pt_t'(-ONE * 4 / 5), pt_t'(ONE * 156 / 1000),
                RADIUS_RESET, MAX_ITER_RESET);
    issue_point('0, '0, 0);
    issue_point(pt_t'(ONE / 2), pt_t'(-ONE / 3), 0);
    issue_point(PT_MAX, PT_MIN, idle_len());
    load_config(MODE_MANDELBROT, pt_t'(ONE / 2), pt_t'(-ONE / 2), RADIUS_RESET, MAX_ITER_RESET);
    issue_point('0, '0, 0);
    issue_point(pt_t'(-ONE), pt_t'(ONE / 4), 0);
  endtask

  // push a component past the z register range: needs a radius above 4.0
  task automatic test_saturation();
    load_config(MODE_JULIA, PT_MAX, PT_MAX, RAD_TOP, MAX_ITER_RESET);
    issue_point(pt_t'(7 * ONE), '0, 0);
    issue_point(pt_t'(5 * ONE), pt_t'(5 * ONE), 0);
    load_config(MODE_JULIA, PT_MIN, '0, RAD_TOP, MAX_ITER_RESET);
    issue_point('0, pt_t'(7 * ONE), 0);
  endtask

  task automatic test_spare_index();
    load_config(MODE_MANDELBROT, '0, '0, RADIUS_RESET, MAX_ITER_RESET);
    for (int idx = SPARE_FIRST; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    issue_point('0, '0, 0);
    issue_point(pt_t'(-ONE / 2), pt_t'(ONE / 2), 0);
  endtask

  task automatic test_random();
    int unsigned pick;
    mode_t m;
    pt_t fre, fim;
    logic [RAD_W-1:0] r;
    logic [MAX_W-1:0] n;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      m = mode_t'($urandom_range(0, 1));
      if (m == MODE_MANDELBROT && $urandom_range(0, 1) == 0) begin
        fre = '0;
        fim = '0;
      end else begin
        fre = rand_coord();
        fim = rand_coord();
      end
      pick = $urandom_range(0, 19);
      if (pick < 11) r = RADIUS_RESET;
      else if (pick < 14) r = RAD_FOUR;
      else if (pick < 16) r = RAD_W'($urandom_range(0, RAD_FOUR));
      else if (pick < 17) r = '0;
      else r = RAD_W'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 10) n = MAX_W'($urandom_range(0, 24));
      else if (pick < 16) n = MAX_W'($urandom_range(25, 255));
      else if (pick < 19) n = MAX_ITER_RESET;
      else n = MAX_W'($urandom_range(256, 600));
      load_config(m, fre, fim, r, n);
      for (int item = 0; item < PHASE_ITEMS; item++) begin
        if ($urandom_range(0, 39) == 0) settle_results();
        issue_point(rand_coord(), rand_coord(), (phase % 5 == 0) ? 0 : idle_len());
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, iteration_count", iteration_count, -1);
      end else begin
        want_result = pending_results.pop_front();
        if (iteration_count !== want_result.count)
          report_mismatch("iteration_count", iteration_count, want_result.count);
        if (inside_res !== want_result.inside_flag)
          report_mismatch("inside_res", inside_res, want_result.inside_flag);
        if (color_index !== want_result.color)
          report_mismatch("color_index", color_index, want_result.color);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_default_config();
    test_iteration_limits();
    test_radius_extremes();
    test_julia();
    test_saturation();
    test_spare_index();
    test_random();
    settle_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/etfp_pkg.sv
rtl/core/etfp_cfg.sv
rtl/core/etfp_dp.sv
rtl/core/etfp_ctrl.sv
rtl/core/escape_time_fractal_pixel.sv
test/escape_time_fractal_pixel_tb.sv
